// ----- src/fragment_reassembly_tracker_assert.svh -----
// Assertion macros for the fragment reassembly tracker.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define FRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define FRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/frt_pkg.sv -----
// Shared types and constants of the fragment reassembly tracker.
// No dependencies.
`timescale 1ns / 1ps

package frt_pkg;

  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned StatW       = 7;

  typedef logic [StatW-1:0] stat_cnt_t;

  typedef enum logic [1:0] {
    REQ_DATA   = 2'd0,
    REQ_ACK    = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    KIND_PENDING  = 3'd0,
    KIND_DUP      = 3'd1,
    KIND_ACK      = 3'd2,
    KIND_MISSING  = 3'd3,
    KIND_RANGE    = 3'd4,
    KIND_BADFIRST = 3'd5
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_DIV,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FLUSH,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    req_type_e   req;
    logic [15:0] idx;
    logic        idx_hi;
    logic [15:0] pay;
    logic        pay_bad;
    logic [31:0] mlen;
    logic        mlen_zero;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    result_kind_e kind;
    logic [5:0]   slot;
    logic         last;
  } res_t;

  typedef struct packed {
    logic      known;
    stat_cnt_t expected;
    stat_cnt_t received;
    stat_cnt_t slot_count;
  } status_t;

endpackage

// ----- src/frt_if.sv -----
// Handshake channels of the fragment reassembly tracker: input, result, config.
// No dependencies.
`timescale 1ns / 1ps

interface frt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] frag_index;
  logic [15:0] frag_len;
  logic [31:0] first_msg_len;
  logic [31:0] now_ms;

  modport source (output valid, req_type, frag_index, frag_len, first_msg_len, now_ms,
                  input ready);
  modport sink (input valid, req_type, frag_index, frag_len, first_msg_len, now_ms,
                output ready);
endinterface

interface frt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [5:0] missing_slot;
  logic       last;

  modport source (output valid, result_kind, missing_slot, last, input ready);
  modport sink (input valid, result_kind, missing_slot, last, output ready);
endinterface

interface frt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] missing_gap_ms;

  modport source (output valid, missing_gap_ms, input ready);
  modport sink (input valid, missing_gap_ms, output ready);
endinterface

// ----- src/fragment_reassembly_tracker.sv -----
// Top level of the fragment reassembly tracker.
// Depends on frt_pkg, frt_if, frt_front, frt_cmd_fifo, frt_back and the assert header.
//
//   channel  dir  payload                                               handshake
//   in_i     in   req_type, frag_index, frag_len, first_msg_len, now_ms  valid/ready
//   res_o    out  result_kind, missing_slot, last                       valid/ready
//   cfg_i    in   missing_gap_ms                                        valid/ready
//
// Clear and unused words return to idle from dispatch, a bad first fragment goes straight
// to emit, data and out-of-range words pass the check first; the first fragment finds its
// fragment count by repeated add of the payload, up to MAX_FRAGS.
// An in-range ack on an incomplete message scans the known slots through the report time
// store, a read and an evaluate step per slot. Reset clears state at once, no sweep.
// A stalled result holds the scan; the two-entry command queue takes words until full.
`timescale 1ns / 1ps
`include "fragment_reassembly_tracker_assert.svh"

module fragment_reassembly_tracker #(
  parameter int unsigned MAX_FRAGS = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  frt_in_if.sink    in_i,
  frt_out_if.source res_o,
  frt_cfg_if.sink   cfg_i
);

  localparam frt_pkg::stat_cnt_t SlotMax = frt_pkg::stat_cnt_t'(MAX_FRAGS);

  frt_pkg::cmd_t    front_cmd, fifo_cmd;
  logic             front_valid, front_ready, fifo_valid, fifo_ready;
  frt_pkg::res_t    res;
  frt_pkg::status_t status;
  logic [15:0]      gap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 16'd100;
    end else if (cfg_i.valid) begin
      gap_q <= cfg_i.missing_gap_ms;
    end
  end

  frt_front #(.MAX_FRAGS(MAX_FRAGS)) u_front (
    .in_i       (in_i),
    .cmd_o      (front_cmd),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready)
  );

  frt_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_data_i (front_cmd),
    .wr_valid_i(front_valid),
    .wr_ready_o(front_ready),
    .rd_data_o (fifo_cmd),
    .rd_valid_o(fifo_valid),
    .rd_ready_i(fifo_ready)
  );

  frt_back #(.MAX_FRAGS(MAX_FRAGS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (fifo_cmd),
    .cmd_valid_i(fifo_valid),
    .cmd_ready_o(fifo_ready),
    .gap_i      (gap_q),
    .res_o      (res),
    .res_valid_o(res_o.valid),
    .res_ready_i(res_o.ready),
    .status_o   (status)
  );

  assign res_o.result_kind  = res.kind;
  assign res_o.missing_slot = res.slot;
  assign res_o.last         = res.last;

  `FRT_ASSERT_IMPL(a_known_cnt, status.known, status.expected != '0, "count missing when known")
  `FRT_ASSERT_IMPL(a_unknown_zero, !status.known, status.expected == '0, "count set while unknown")
  `FRT_ASSERT(a_slots, status.slot_count != '0 && status.slot_count <= SlotMax, "bad slot count")

endmodule

// ----- src/frt_front.sv -----
// Front end: takes input words and pre-classifies them into commands.
// Depends on frt_pkg and frt_in_if.
`timescale 1ns / 1ps

module frt_front #(
  parameter int unsigned MAX_FRAGS = 64
) (
  frt_in_if.sink       in_i,
  output frt_pkg::cmd_t cmd_o,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i
);

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;

  always_comb begin
    cmd_o.req       = frt_pkg::req_type_e'(in_i.req_type);
    cmd_o.idx       = in_i.frag_index;
    cmd_o.idx_hi    = in_i.frag_index >= 16'(MAX_FRAGS);
    cmd_o.pay       = in_i.frag_len - 16'(frt_pkg::HeaderBytes);
    cmd_o.pay_bad   = in_i.frag_len <= 16'(frt_pkg::HeaderBytes);
    cmd_o.mlen      = in_i.first_msg_len;
    cmd_o.mlen_zero = in_i.first_msg_len == 32'd0;
    cmd_o.now       = in_i.now_ms;
  end

endmodule

// ----- src/frt_cmd_fifo.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on frt_pkg.
`timescale 1ns / 1ps

module frt_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  frt_pkg::cmd_t wr_data_i,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  output frt_pkg::cmd_t rd_data_o,
  output logic          rd_valid_o,
  input  logic          rd_ready_i
);

  frt_pkg::cmd_t entry_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = entry_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wp_q] <= wr_data_i;
    end
  end

endmodule

// ----- src/frt_back.sv -----
// Back end: message state, count division, slot scan and result register.
// Depends on frt_pkg.
`timescale 1ns / 1ps

module frt_back #(
  parameter int unsigned MAX_FRAGS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frt_pkg::cmd_t    cmd_i,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  logic [15:0]      gap_i,
  output frt_pkg::res_t    res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output frt_pkg::status_t status_o
);

  localparam int unsigned IW = $clog2(MAX_FRAGS);
  localparam int unsigned CW = $clog2(MAX_FRAGS + 1);
  localparam int unsigned AW = 16 + CW;

  frt_pkg::back_state_e state_q, state_d;
  frt_pkg::cmd_t        cur_q, cur_d;
  logic                 known_q, known_d;
  logic [CW-1:0]        expected_q, expected_d;
  logic [CW-1:0]        received_q, received_d;
  logic [CW-1:0]        slot_count_q, slot_count_d;
  logic [MAX_FRAGS-1:0] filled_q, filled_d;
  logic [MAX_FRAGS-1:0] rt_valid_q, rt_valid_d;
  logic [31:0]          rt_mem [MAX_FRAGS];
  logic [31:0]          rd_data_q;
  logic                 rd_valid_q;
  logic [CW-1:0]        scan_q, scan_d;
  logic [AW-1:0]        acc_q, acc_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [IW-1:0]        held_q, held_d;
  logic                 have_held_q, have_held_d;
  frt_pkg::res_t        emit_q, emit_d;
  frt_pkg::res_t        res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  logic          out_free, push;
  frt_pkg::res_t push_res;
  logic [AW-1:0] acc_sum;
  logic [CW-1:0] cnt_inc;
  logic          div_done, first_frag, range_bad, complete_now;
  logic [CW-1:0] idx_w;
  logic [IW-1:0] idx_s, scan_s;
  logic [31:0]   rt_val, age;
  logic          due, stall, mem_we;

  assign out_free     = !res_valid_q || res_ready_i;
  assign cmd_ready_o  = state_q == frt_pkg::ST_IDLE;
  assign acc_sum      = acc_q + AW'(cur_q.pay);
  assign cnt_inc      = cnt_q + CW'(1);
  assign div_done     = 32'(acc_sum) >= cur_q.mlen;
  assign first_frag   = !known_q && cur_q.idx == 16'd0;
  assign idx_w        = cur_q.idx[CW-1:0];
  assign idx_s        = cur_q.idx[IW-1:0];
  assign range_bad    = cur_q.idx_hi || (known_q && idx_w >= expected_q);
  assign complete_now = known_q && received_q == expected_q;
  assign scan_s       = scan_q[IW-1:0];
  assign rt_val       = rd_valid_q ? rd_data_q : 32'd0;
  assign age          = cur_q.now - rt_val;
  assign due          = !filled_q[scan_s] && (rt_val == 32'd0 || age > {16'd0, gap_i});
  assign stall        = due && have_held_q && !out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      frt_pkg::ST_IDLE: begin
        if (cmd_valid_i) state_d = frt_pkg::ST_DISP;
      end
      frt_pkg::ST_DISP: begin
        if (cur_q.req == frt_pkg::REQ_CLEAR || cur_q.req == frt_pkg::REQ_UNUSED) begin
          state_d = frt_pkg::ST_IDLE;
        end else if (first_frag) begin
          state_d = (cur_q.pay_bad || cur_q.mlen_zero) ? frt_pkg::ST_EMIT : frt_pkg::ST_DIV;
        end else begin
          state_d = frt_pkg::ST_CHECK;
        end
      end
      frt_pkg::ST_DIV: begin
        if (div_done) state_d = frt_pkg::ST_CHECK;
        else if (cnt_inc == CW'(MAX_FRAGS)) state_d = frt_pkg::ST_EMIT;
      end
      frt_pkg::ST_CHECK: begin
        if (range_bad || cur_q.req == frt_pkg::REQ_DATA || complete_now) begin
          state_d = frt_pkg::ST_EMIT;
        end else begin
          state_d = frt_pkg::ST_SCAN_RD;
        end
      end
      frt_pkg::ST_SCAN_RD: begin
        state_d = (scan_q >= slot_count_q) ? frt_pkg::ST_FLUSH : frt_pkg::ST_SCAN_EV;
      end
      frt_pkg::ST_SCAN_EV: begin
        if (!stall) state_d = frt_pkg::ST_SCAN_RD;
      end
      frt_pkg::ST_FLUSH, frt_pkg::ST_EMIT: begin
        if (out_free) state_d = frt_pkg::ST_IDLE;
      end
      default: state_d = frt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cur_d        = cur_q;
    known_d      = known_q;
    expected_d   = expected_q;
    received_d   = received_q;
    slot_count_d = slot_count_q;
    filled_d     = filled_q;
    rt_valid_d   = rt_valid_q;
    scan_d       = scan_q;
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    held_d       = held_q;
    have_held_d  = have_held_q;
    emit_d       = emit_q;
    push         = 1'b0;
    push_res     = emit_q;
    mem_we       = 1'b0;
    unique case (state_q)
      frt_pkg::ST_IDLE: begin
        if (cmd_valid_i) cur_d = cmd_i;
      end
      frt_pkg::ST_DISP: begin
        acc_d = '0;
        cnt_d = '0;
        if (cur_q.req == frt_pkg::REQ_CLEAR) begin
          filled_d     = '0;
          rt_valid_d   = '0;
          slot_count_d = CW'(1);
          known_d      = 1'b0;
          expected_d   = '0;
          received_d   = '0;
        end
        emit_d = '{kind: frt_pkg::KIND_BADFIRST, slot: 6'd0, last: 1'b1};
      end
      frt_pkg::ST_DIV: begin
        acc_d = acc_sum;
        cnt_d = cnt_inc;
        if (div_done) begin
          known_d    = 1'b1;
          expected_d = cnt_inc;
        end
        emit_d = '{kind: frt_pkg::KIND_RANGE, slot: 6'd0, last: 1'b1};
      end
      frt_pkg::ST_CHECK: begin
        scan_d      = '0;
        have_held_d = 1'b0;
        if (range_bad) begin
          emit_d = '{kind: frt_pkg::KIND_RANGE, slot: 6'd0, last: 1'b1};
        end else begin
          if (idx_w >= slot_count_q) slot_count_d = idx_w + CW'(1);
          if (cur_q.req == frt_pkg::REQ_ACK) begin
            emit_d = '{kind: frt_pkg::KIND_ACK, slot: 6'd0, last: 1'b1};
          end else if (filled_q[idx_s]) begin
            emit_d = '{kind: frt_pkg::KIND_DUP, slot: 6'd0, last: 1'b1};
          end else begin
            filled_d[idx_s] = 1'b1;
            received_d      = received_q + CW'(1);
            emit_d = '{kind: (known_q && received_d == expected_q) ?
                             frt_pkg::KIND_ACK : frt_pkg::KIND_PENDING,
                       slot: 6'd0, last: 1'b1};
          end
        end
      end
      frt_pkg::ST_SCAN_EV: begin
        if (!stall) begin
          scan_d = scan_q + CW'(1);
          if (due) begin
            // hand the earlier hit out, keep this one until the next hit or the end of the scan
            mem_we             = 1'b1;
            rt_valid_d[scan_s] = 1'b1;
            push               = have_held_q;
            push_res = '{kind: frt_pkg::KIND_MISSING, slot: 6'(held_q), last: 1'b0};
            held_d             = scan_s;
            have_held_d        = 1'b1;
          end
        end
      end
      frt_pkg::ST_FLUSH: begin
        push = out_free;
        if (have_held_q) begin
          push_res = '{kind: frt_pkg::KIND_MISSING, slot: 6'(held_q), last: 1'b1};
        end else begin
          push_res = '{kind: frt_pkg::KIND_PENDING, slot: 6'd0, last: 1'b1};
        end
      end
      frt_pkg::ST_EMIT: begin
        push = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d       = push ? push_res : res_q;
    res_valid_d = push ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= frt_pkg::ST_IDLE;
      known_q      <= 1'b0;
      expected_q   <= '0;
      received_q   <= '0;
      slot_count_q <= CW'(1);
      filled_q     <= '0;
      rt_valid_q   <= '0;
      scan_q       <= '0;
      cnt_q        <= '0;
      have_held_q  <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      known_q      <= known_d;
      expected_q   <= expected_d;
      received_q   <= received_d;
      slot_count_q <= slot_count_d;
      filled_q     <= filled_d;
      rt_valid_q   <= rt_valid_d;
      scan_q       <= scan_d;
      cnt_q        <= cnt_d;
      have_held_q  <= have_held_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    acc_q  <= acc_d;
    held_q <= held_d;
    emit_q <= emit_d;
    res_q  <= res_d;
  end

  // Report time store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rt_mem[scan_s] <= cur_q.now;
    end
    if (state_q == frt_pkg::ST_SCAN_RD) begin
      rd_data_q  <= rt_mem[scan_s];
      rd_valid_q <= rt_valid_q[scan_s];
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_comb begin
    status_o.known      = known_q;
    status_o.expected   = frt_pkg::stat_cnt_t'(expected_q);
    status_o.received   = frt_pkg::stat_cnt_t'(received_q);
    status_o.slot_count = frt_pkg::stat_cnt_t'(slot_count_q);
  end

endmodule

// ----- test/fragment_reassembly_tracker_tb.sv -----
// Testbench of the fragment reassembly tracker: directed and random word traffic,
// checked against an in-bench scoreboard of the slot tracking. Needs frt_pkg, frt_if.
`timescale 1ns / 1ps

module fragment_reassembly_tracker_tb;

  localparam int unsigned MaxFrags   = 64;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned SettleCyc  = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  frt_in_if  in_if();
  frt_out_if res_if();
  frt_cfg_if cfg_if();

  fragment_reassembly_tracker #(.MAX_FRAGS(MaxFrags)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // scoreboard copy of the tracker state
  logic [15:0] gap_ms;
  logic        filled[MaxFrags];
  logic [31:0] stamp[MaxFrags];
  logic [6:0]  slots_known;
  logic        count_known;
  logic [6:0]  frag_total;
  logic [6:0]  frag_seen;

  frt_pkg::res_t expected_res_q[$];
  int   mismatches = 0;
  int   words_sent = 0;
  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  int   hold_cnt = 0;
  int   stall_cnt = 0;
  int   quiet_cnt = 0;
  logic [31:0] clock_ms;

  function automatic void clear_tracker();
    for (int i = 0; i < MaxFrags; i++) begin
      filled[i] = 1'b0;
      stamp[i] = '0;
    end
    slots_known = 7'd1;
    count_known = 1'b0;
    frag_total = '0;
    frag_seen = '0;
  endfunction

  function automatic void push_res(frt_pkg::result_kind_e kind, logic [5:0] slot, logic last);
    frt_pkg::res_t r;
    r.kind = kind;
    r.slot = slot;
    r.last = last;
    expected_res_q.insert(expected_res_q.size(), r);
  endfunction

  // Work out the result words caused by one accepted input word.
  function automatic void predict_results(frt_pkg::req_type_e req, logic [15:0] idx,
                                          logic [15:0] flen, logic [31:0] mlen,
                                          logic [31:0] now);
    logic [63:0] pay;
    logic [63:0] cnt;
    int          n;
    logic [31:0] age;
    n = 0;
    if (req == frt_pkg::REQ_CLEAR) begin
      clear_tracker();
      return;
    end
    if (req == frt_pkg::REQ_UNUSED) return;
    if (!count_known && idx == 16'd0) begin
      if (flen <= frt_pkg::HeaderBytes) begin
        push_res(frt_pkg::KIND_BADFIRST, '0, 1'b1);
        return;
      end
      pay = 64'(flen) - 64'(frt_pkg::HeaderBytes);
      if (64'(mlen) == pay) cnt = 64'd1;
      else cnt = (64'(mlen) + pay - 64'd1) / pay;
      if (cnt == 0) begin
        push_res(frt_pkg::KIND_BADFIRST, '0, 1'b1);
        return;
      end
      if (cnt > MaxFrags) begin
        push_res(frt_pkg::KIND_RANGE, '0, 1'b1);
        return;
      end
      count_known = 1'b1;
      frag_total = 7'(cnt);
    end
    if (idx >= MaxFrags || (count_known && idx >= 16'(frag_total))) begin
      push_res(frt_pkg::KIND_RANGE, '0, 1'b1);
      return;
    end
    if (idx >= 16'(slots_known)) slots_known = 7'(idx + 1);
    if (req == frt_pkg::REQ_ACK) begin
      if (count_known && frag_seen == frag_total) begin
        push_res(frt_pkg::KIND_ACK, '0, 1'b1);
        return;
      end
      for (int i = 0; i < slots_known; i++) begin
        age = now - stamp[i];
        if (!filled[i] && (stamp[i] == 0 || age > 32'(gap_ms))) begin
          stamp[i] = now;
          push_res(frt_pkg::KIND_MISSING, 6'(i), 1'b0);
          n++;
        end
      end
      if (n == 0) push_res(frt_pkg::KIND_PENDING, '0, 1'b1);
      else expected_res_q[$].last = 1'b1;
      return;
    end
    if (filled[idx]) begin
      push_res(frt_pkg::KIND_DUP, '0, 1'b1);
      return;
    end
    filled[idx] = 1'b1;
    frag_seen = frag_seen + 7'd1;
    push_res((count_known && frag_seen == frag_total) ? frt_pkg::KIND_ACK :
             frt_pkg::KIND_PENDING, '0, 1'b1);
  endfunction

  // Leaves valid high after the handshake; the next call or a drain lowers or reloads it.
  task automatic send_word(frt_pkg::req_type_e req, logic [15:0] idx, logic [15:0] flen,
                           logic [31:0] mlen, logic [31:0] now);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.frag_index <= idx;
    in_if.frag_len <= flen;
    in_if.first_msg_len <= mlen;
    in_if.now_ms <= now;
    do @(posedge clk_i); while (!in_if.ready);
    predict_results(req, idx, flen, mlen, now);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_res_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_gap(logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.missing_gap_ms <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    gap_ms = value;
  endtask

  task automatic test_special_cases();
    send_word(frt_pkg::REQ_DATA, 16'd0, 16'd16, 32'd100, 32'd5);
    send_word(frt_pkg::REQ_DATA, 16'd0, 16'd0, 32'd5, 32'd5);
    send_word(frt_pkg::REQ_DATA, 16'd0, 16'd20, 32'd0, 32'd5);
    send_word(frt_pkg::REQ_DATA, 16'd0, 16'd17, 32'd65, 32'd5);
    send_word(frt_pkg::REQ_DATA, 16'd0, 16'hffff, 32'hffff_ffff, 32'd5);
    send_word(frt_pkg::REQ_DATA, 16'hffff, 16'd40, 32'd10, 32'd5);
    send_word(frt_pkg::REQ_UNUSED, 16'h5a5a, 16'ha5a5, 32'h1234_5678, 32'd5);
    send_word(frt_pkg::REQ_ACK, 16'd2, 16'd0, 32'd0, 32'd50);
    send_word(frt_pkg::REQ_ACK, 16'd0, 16'd116, 32'd300, 32'd60);
    send_word(frt_pkg::REQ_DATA, 16'd1, 16'd116, 32'd0, 32'd70);
    send_word(frt_pkg::REQ_DATA, 16'd1, 16'd116, 32'd0, 32'd71);
    send_word(frt_pkg::REQ_DATA, 16'd3, 16'd116, 32'd0, 32'd72);
    send_word(frt_pkg::REQ_ACK, 16'd0, 16'd0, 32'd0, 32'hffff_ffff);
    send_word(frt_pkg::REQ_DATA, 16'd0, 16'd116, 32'd300, 32'd80);
    send_word(frt_pkg::REQ_DATA, 16'd2, 16'd116, 32'd0, 32'd81);
    send_word(frt_pkg::REQ_ACK, 16'd1, 16'd0, 32'd0, 32'd90);
    send_word(frt_pkg::REQ_CLEAR, 16'd0, 16'd0, 32'd0, 32'd0);
    send_word(frt_pkg::REQ_DATA, 16'd0, 16'd50, 32'd34, 32'd100);
    send_word(frt_pkg::REQ_DATA, 16'd63, 16'd50, 32'd34, 32'd100);
    send_word(frt_pkg::REQ_CLEAR, 16'd0, 16'd0, 32'd0, 32'd0);
    send_word(frt_pkg::REQ_DATA, 16'd63, 16'd80, 32'd0, 32'd0);
    send_word(frt_pkg::REQ_ACK, 16'd0, 16'd80, 32'd4096, 32'd0);
    send_word(frt_pkg::REQ_ACK, 16'd5, 16'd80, 32'd4096, 32'd0);
  endtask

  // One message: clear, fragments in random order with duplicates, acks and strays.
  task automatic run_message(int unsigned max_cnt);
    int unsigned cnt;
    int unsigned pay;
    logic [31:0] mlen;
    int unsigned order[$];
    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_cnt) : $urandom_range(1, 8);
    pay = $urandom_range(1, 300);
    mlen = (cnt == 1) ? pay : (cnt - 1) * pay + $urandom_range(1, pay);
    send_word(frt_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), $urandom, clock_ms);
    for (int unsigned i = 0; i < cnt; i++) order.insert(order.size(), i);
    order.shuffle();
    if ($urandom_range(0, 1) == 0) begin
      send_word(frt_pkg::REQ_DATA, 16'd0, 16'(pay + frt_pkg::HeaderBytes), mlen, clock_ms);
    end
    foreach (order[i]) begin
      if ($urandom_range(0, 6) == 0) continue;
      clock_ms += $urandom_range(0, 150);
      case ($urandom_range(0, 9))
        0, 1: send_word(frt_pkg::REQ_ACK, 16'($urandom_range(0, cnt - 1)),
                        16'(pay + frt_pkg::HeaderBytes), mlen, clock_ms);
        2: send_word(frt_pkg::REQ_DATA, 16'($urandom_range(cnt, cnt + 70)),
                     16'(pay + frt_pkg::HeaderBytes), mlen, clock_ms);
        3: send_word(frt_pkg::req_type_e'($urandom_range(0, 3)), 16'($urandom),
                     16'($urandom), $urandom, $urandom);
        default: ;
      endcase
      send_word(frt_pkg::REQ_DATA, 16'(order[i]), 16'(pay + frt_pkg::HeaderBytes), mlen,
                clock_ms);
      if ($urandom_range(0, 5) == 0) begin
        send_word(frt_pkg::REQ_DATA, 16'(order[i]), 16'(pay + frt_pkg::HeaderBytes), mlen,
                  clock_ms);
      end
    end
    clock_ms += $urandom_range(0, 300);
    send_word(frt_pkg::REQ_ACK, 16'd0, 16'(pay + frt_pkg::HeaderBytes), mlen, clock_ms);
  endtask

  task automatic test_random_traffic(int unsigned target, int unsigned max_cnt);
    while (words_sent < target) run_message(max_cnt);
  endtask

  // Fill the result path with full scans while the receiver is held off.
  task automatic test_result_stall();
    send_word(frt_pkg::REQ_CLEAR, 16'd0, 16'd0, 32'd0, clock_ms);
    send_word(frt_pkg::REQ_DATA, 16'd0, 16'd17, 32'd64, clock_ms);
    hold_req <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      clock_ms += 1000;
      send_word(frt_pkg::REQ_ACK, 16'd63, 16'd17, 32'd64, clock_ms);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = frt_pkg::REQ_DATA;
    in_if.frag_index = '0;
    in_if.frag_len = '0;
    in_if.first_msg_len = '0;
    in_if.now_ms = '0;
    cfg_if.valid = 1'b0;
    cfg_if.missing_gap_ms = '0;
    gap_ms = 16'd100;
    clock_ms = 32'd1;
    clear_tracker();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    wait_drained();
    write_gap(16'd0);
    test_random_traffic(100, 64);
    wait_drained();
    write_gap(16'hffff);
    clock_ms = 32'hffff_f000;
    test_random_traffic(160, 16);
    wait_drained();
    write_gap(16'd100);
    test_result_stall();
    test_random_traffic(260, 64);
    wait_drained();
    write_gap(16'($urandom_range(1, 400)));
    idle_on <= 1'b0;
    // keep a stretch without idling even when the earlier phase ran long
    test_random_traffic(int'(words_sent) + 30 > 330 ? int'(words_sent) + 30 : 330, 16);
    wait_drained();

    if (mismatches == 0 && expected_res_q.size() == 0) begin
      $display("** fragment_reassembly_tracker: PASSED **");
    end else begin
      $display("** fragment_reassembly_tracker: FAILED **");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, and the check of each word.
  always @(posedge clk_i or negedge rst_ni) begin
    frt_pkg::res_t e;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_res_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result kind %0d slot %0d last %0d",
                                        res_if.result_kind, res_if.missing_slot, res_if.last);
          mismatches++;
        end else begin
          e = expected_res_q.pop_front();
          if (res_if.result_kind != e.kind || res_if.missing_slot != e.slot ||
              res_if.last != e.last) begin
            if (mismatches < 10) begin
              $display("result mismatch: exp kind %0d slot %0d last %0d, got %0d %0d %0d",
                       e.kind, e.slot, e.last, res_if.result_kind, res_if.missing_slot,
                       res_if.last);
            end
            mismatches++;
          end
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_req <= 1'b0;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(0, 13);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
      if (quiet_cnt >= WatchLimit) begin
        $display("** fragment_reassembly_tracker: FAILED **");
        $finish;
      end
    end
  end

endmodule
